/* hdl/sam_pkg.sv */
`timescale 1ns / 1ps
// sam_pkg: shared constants, codes and types of the stack arithmetic machine
// depends on nothing; used by the interfaces, the divider and the core
package sam_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = 7;
	localparam int ACT_W       = 3;
	localparam int STATUS_W    = 3;
	localparam int IO_W        = 32;
	localparam int STEP_W      = $clog2(VALUE_WIDTH);

	typedef logic signed [VALUE_WIDTH-1:0] value_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH = 3'd0,
		ACT_ADD  = 3'd1,
		ACT_MUL  = 3'd2,
		ACT_SUB  = 3'd3,
		ACT_DIV  = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_UNDER   = 3'd1,
		ST_OVER    = 3'd2,
		ST_DIVZERO = 3'd3,
		ST_UNKNOWN = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_WB,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic   start;
		value_t dividend;
		value_t divisor;
	} div_req_t;

	typedef struct packed {
		logic   done;
		value_t quotient;
	} div_rsp_t;

endpackage

/* hdl/sam_if.sv */
`timescale 1ns / 1ps
// sam_in_if, sam_out_if: valid/ready channels for commands and results
// depends on sam_pkg for the field widths
interface sam_in_if;
	logic                          valid;
	logic                          ready;
	logic [sam_pkg::ACT_W-1:0]     action;
	logic signed [sam_pkg::IO_W-1:0] operand_value;

	modport source(output valid, output action, output operand_value, input ready);
	modport sink(input valid, input action, input operand_value, output ready);
endinterface

interface sam_out_if;
	logic                            valid;
	logic                            ready;
	logic signed [sam_pkg::IO_W-1:0] top_value;
	logic [sam_pkg::CNT_W-1:0]       stack_depth;
	logic [sam_pkg::STATUS_W-1:0]    status;

	modport source(output valid, output top_value, output stack_depth, output status,
		input ready);
	modport sink(input valid, input top_value, input stack_depth, input status,
		output ready);
endinterface

/* hdl/sam_div.sv */
`timescale 1ns / 1ps
// sam_div: iterative signed divider, one quotient bit per cycle, truncating
// depends on sam_pkg (value_t, div_req_t, div_rsp_t, STEP_W)
module sam_div (
	input  logic              clk,
	input  logic              arst_n,
	input  sam_pkg::div_req_t req,
	output sam_pkg::div_rsp_t rsp
);

	localparam int W = sam_pkg::VALUE_WIDTH;

	logic                        busy_q;
	logic                        done_q;
	logic                        neg_q;
	logic [sam_pkg::STEP_W-1:0]  step_q;
	logic [W-1:0]                rem_q;
	logic [W-1:0]                quo_q;
	logic [W-1:0]                dvs_q;
	logic [W:0]                  trial;
	logic                        take;
	logic [W-1:0]                mag_a;
	logic [W-1:0]                mag_b;

	assign mag_a = req.dividend[W-1] ? (W'(0) - W'(req.dividend)) : W'(req.dividend);
	assign mag_b = req.divisor[W-1] ? (W'(0) - W'(req.divisor)) : W'(req.divisor);
	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};
	assign take  = !trial[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + sam_pkg::STEP_W'(1);
				if (step_q == sam_pkg::STEP_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= mag_a;
			dvs_q <= mag_b;
			neg_q <= req.dividend[W-1] ^ req.divisor[W-1];
		end else if (busy_q) begin
			rem_q <= take ? trial[W-1:0] : {rem_q[W-2:0], quo_q[W-1]};
			quo_q <= {quo_q[W-2:0], take};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? sam_pkg::value_t'(W'(0) - quo_q) : sam_pkg::value_t'(quo_q);

endmodule

/* hdl/stack_arithmetic_machine_core.sv */
`timescale 1ns / 1ps
// stack_arithmetic_machine_core: stack calculator with the stack in a synchronous ram
// depends on sam_pkg, sam_in_if, sam_out_if and sam_div
//
//   port  dir  transfer carries
//   cmd   in   action, operand_value
//   rsp   out  top_value, stack_depth, status
//
// push and commands rejected at accept go straight to finish, divide by zero
// via exec, add, subtract and multiply via exec and write back, divide via exec,
// divide wait and write back: the divider retires one quotient bit per cycle
// the top entry is kept in a register, the entry below comes from the ram read port
// reset clears the entry count; stack ram contents are not reset
// a new command is taken while the previous result still waits on rsp
module stack_arithmetic_machine_core (
	input  logic        clk,
	input  logic        arst_n,
	sam_in_if.sink      cmd,
	sam_out_if.source   rsp
);

	sam_pkg::value_t             stack_mem [sam_pkg::STACK_DEPTH];
	sam_pkg::value_t             rd_data_q;

	sam_pkg::state_t             state_q;
	sam_pkg::state_t             state_d;
	sam_pkg::action_t            action_q;
	sam_pkg::status_t            status_q;
	logic [sam_pkg::CNT_W-1:0]   cnt_q;
	sam_pkg::value_t             top_q;
	sam_pkg::value_t             res_q;

	logic                        out_valid_q;
	sam_pkg::value_t             out_top_q;
	logic [sam_pkg::CNT_W-1:0]   out_depth_q;
	sam_pkg::status_t            out_status_q;

	logic                        accept;
	sam_pkg::action_t            cmd_act;
	logic                        is_push;
	logic                        is_unknown;
	logic                        is_full;
	logic                        is_under;
	logic [sam_pkg::CNT_W-1:0]   cnt_m2;
	logic [sam_pkg::ADDR_W-1:0]  second_addr;
	sam_pkg::value_t             push_val;
	sam_pkg::value_t             arith;

	logic                        mem_we;
	logic [sam_pkg::ADDR_W-1:0]  mem_waddr;
	sam_pkg::value_t             mem_wdata;
	logic                        load_out;
	logic                        div_zero;
	sam_pkg::div_req_t           div_req;
	sam_pkg::div_rsp_t           div_rsp;

	assign accept      = cmd.valid && cmd.ready;
	assign cmd_act     = sam_pkg::action_t'(cmd.action);
	assign is_push     = cmd_act == sam_pkg::ACT_PUSH;
	assign is_unknown  = cmd.action > sam_pkg::ACT_DIV;
	assign is_full     = cnt_q >= sam_pkg::CNT_W'(sam_pkg::STACK_DEPTH);
	assign is_under    = cnt_q < sam_pkg::CNT_W'(2);
	assign cnt_m2      = cnt_q - sam_pkg::CNT_W'(2);
	assign second_addr = cnt_m2[sam_pkg::ADDR_W-1:0];
	assign push_val    = sam_pkg::value_t'(cmd.operand_value);
	assign div_zero    = rd_data_q == '0;

	// stack ram: one write port, one registered read port on the second entry
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= stack_mem[second_addr];
	end

	always_comb begin
		case (action_q)
			sam_pkg::ACT_ADD: arith = top_q + rd_data_q;
			sam_pkg::ACT_SUB: arith = top_q - rd_data_q;
			sam_pkg::ACT_MUL: arith = sam_pkg::value_t'(top_q * rd_data_q);
			default:          arith = '0;
		endcase
	end

	sam_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sam_pkg::S_IDLE: begin
				if (accept) begin
					if (is_push || is_unknown || is_under) begin
						state_d = sam_pkg::S_FINISH;
					end else begin
						state_d = sam_pkg::S_EXEC;
					end
				end
			end
			sam_pkg::S_EXEC: begin
				if (action_q == sam_pkg::ACT_DIV) begin
					state_d = div_zero ? sam_pkg::S_FINISH : sam_pkg::S_DIV;
				end else begin
					state_d = sam_pkg::S_WB;
				end
			end
			sam_pkg::S_DIV: begin
				if (div_rsp.done) begin
					state_d = sam_pkg::S_WB;
				end
			end
			sam_pkg::S_WB: state_d = sam_pkg::S_FINISH;
			sam_pkg::S_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = sam_pkg::S_IDLE;
				end
			end
			default: state_d = sam_pkg::S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		mem_we           = 1'b0;
		mem_waddr        = cnt_q[sam_pkg::ADDR_W-1:0];
		mem_wdata        = push_val;
		load_out         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = top_q;
		div_req.divisor  = rd_data_q;
		case (state_q)
			sam_pkg::S_IDLE: mem_we = accept && is_push && !is_full;
			sam_pkg::S_EXEC: div_req.start = (action_q == sam_pkg::ACT_DIV) && !div_zero;
			sam_pkg::S_WB: begin
				mem_we    = 1'b1;
				mem_waddr = second_addr;
				mem_wdata = res_q;
			end
			sam_pkg::S_FINISH: load_out = !out_valid_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sam_pkg::S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sam_pkg::S_IDLE && accept && is_push && !is_full) begin
				cnt_q <= cnt_q + sam_pkg::CNT_W'(1);
			end else if (state_q == sam_pkg::S_WB) begin
				cnt_q <= cnt_q - sam_pkg::CNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sam_pkg::S_IDLE && accept) begin
			action_q <= cmd_act;
			if (is_push) begin
				status_q <= is_full ? sam_pkg::ST_OVER : sam_pkg::ST_OK;
			end else if (is_unknown) begin
				status_q <= sam_pkg::ST_UNKNOWN;
			end else if (is_under) begin
				status_q <= sam_pkg::ST_UNDER;
			end else begin
				status_q <= sam_pkg::ST_OK;
			end
			if (is_push && !is_full) begin
				top_q <= push_val;
			end
		end
		if (state_q == sam_pkg::S_EXEC) begin
			res_q <= arith;
			if (action_q == sam_pkg::ACT_DIV && div_zero) begin
				status_q <= sam_pkg::ST_DIVZERO;
			end
		end
		if (state_q == sam_pkg::S_DIV && div_rsp.done) begin
			res_q <= div_rsp.quotient;
		end
		if (state_q == sam_pkg::S_WB) begin
			top_q <= res_q;
		end
		if (load_out) begin
			out_top_q    <= (cnt_q == '0) ? '0 : top_q;
			out_depth_q  <= cnt_q;
			out_status_q <= status_q;
		end
	end

	assign cmd.ready       = state_q == sam_pkg::S_IDLE;
	assign rsp.valid       = out_valid_q;
	assign rsp.top_value   = sam_pkg::IO_W'(out_top_q);
	assign rsp.stack_depth = out_depth_q;
	assign rsp.status      = out_status_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= sam_pkg::CNT_W'(sam_pkg::STACK_DEPTH))
		else $error("entry count beyond stack depth");

	a_under_no_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_push && !is_unknown && is_under) |=> state_q == sam_pkg::S_FINISH)
		else $error("operation on short stack reached execution");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == sam_pkg::S_DIV)
		else $error("divider finished outside divide wait");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> ($past(state_q) == sam_pkg::S_WB || $past(accept)))
		else $error("entry count moved without a push or write back");

endmodule
